// ===== design/msp_pkg.sv =====
// Shared types and constants for the motor status packet receiver.
// Used by msp_front, msp_back and the top level; no dependencies.
package msp_pkg;

    localparam int PACKET_DEPTH = 32;
    localparam int DATA_LIMIT   = 23;

    localparam int WIDX_W = $clog2(PACKET_DEPTH + 1);
    localparam int DCNT_W = $clog2(DATA_LIMIT + 1);

    localparam logic [7:0] HDR_A         = 8'd183;
    localparam logic [7:0] HDR_B         = 8'd184;
    localparam logic [7:0] ID_ONE        = 8'd1;
    localparam logic [7:0] ID_TWO        = 8'd2;
    localparam logic [7:0] MAIN_DATA_PID = 8'd193;

    // configuration register indexes
    localparam logic [1:0] CFG_MOTOR_A_ID = 2'd0;
    localparam logic [1:0] CFG_MOTOR_B_ID = 2'd1;
    localparam logic [1:0] CFG_ERR_LIMIT  = 2'd2;

    localparam logic [7:0] RST_MOTOR_A_ID = 8'd1;
    localparam logic [7:0] RST_MOTOR_B_ID = 8'd2;
    localparam logic [3:0] RST_ERR_LIMIT  = 4'd10;

    // only these packet bytes are ever read back
    localparam int STORE_SLOTS = 8;
    localparam int SLOT_ID     = 0;
    localparam int SLOT_PID    = 1;
    localparam int SLOT_RPM0   = 2;
    localparam int SLOT_RPM1   = 3;
    localparam int SLOT_POS0   = 4;
    localparam int SLOT_POS1   = 5;
    localparam int SLOT_POS2   = 6;
    localparam int SLOT_POS3   = 7;

    typedef logic [WIDX_W-1:0] t_widx;

    localparam t_widx STORE_MAP [STORE_SLOTS] = '{
        t_widx'(2), t_widx'(3), t_widx'(5), t_widx'(6),
        t_widx'(15), t_widx'(16), t_widx'(17), t_widx'(18)
    };

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_HDR_ERR   = 3'd2,
        ST_ID_ERR    = 3'd3,
        ST_CSUM_ERR  = 3'd4,
        ST_TOO_LONG  = 3'd5,
        ST_ERR_LIMIT = 3'd6
    } t_status;

    typedef enum logic [5:0] {
        PH_HDR  = 6'b000001,
        PH_ID   = 6'b000010,
        PH_PID  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_CSUM = 6'b100000
    } t_phase;

    // classified byte handed from front to back
    typedef struct packed {
        logic       is_hdr;
        logic       is_id;
        logic [7:0] data;
    } t_cls;

endpackage

// ===== design/msp_front.sv =====
// Front end: accepts received bytes, tags header and id bytes, and holds
// them in a two-entry queue for the back end. Depends on msp_pkg.
module msp_front
    import msp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_in_stall,
    output logic       o_q_valid,
    output t_cls       o_q_head,
    input  logic       i_q_pop
);

    t_cls       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_cls       cls;

    always_comb begin
        cls.data   = i_rx_byte;
        cls.is_hdr = (i_rx_byte == HDR_A) || (i_rx_byte == HDR_B);
        cls.is_id  = (i_rx_byte == ID_ONE) || (i_rx_byte == ID_TWO);
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_head   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ i_q_pop;
        n_count  = r_count + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

// ===== design/msp_back.sv =====
// Back end: deframing state machine, checksum, error run counter, packet
// byte store, configuration registers and the result register. Uses msp_pkg.
module msp_back
    import msp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_q_valid,
    input  t_cls               i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_motor_update,
    output logic               o_motor_index,
    output logic [7:0]         o_packet_kind,
    output logic signed [15:0] o_speed_rpm,
    output logic signed [31:0] o_position
);

    logic [7:0] r_motor_a_id;
    logic [7:0] r_motor_b_id;
    logic [3:0] r_err_limit;

    t_phase            r_phase, n_phase;
    logic              r_hdr_cnt, n_hdr_cnt;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_exp_len, n_exp_len;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [3:0]        r_err_run, n_err_run;
    t_widx             r_widx, n_widx;
    logic [7:0]        r_store [STORE_SLOTS];
    logic [7:0]        n_store [STORE_SLOTS];

    logic        r_out_valid;
    t_status     r_status, n_status;
    logic        r_upd, n_upd;
    logic        r_midx, n_midx;
    logic [7:0]  r_kind, n_kind;
    logic [15:0] r_rpm, n_rpm;
    logic [31:0] r_pos, n_pos;

    logic [7:0]        b;
    logic              take;
    logic              restart;
    logic              err;
    logic              err_limit_hit;
    logic [3:0]        err_inc;
    logic [3:0]        lim;
    logic [7:0]        sum_add;
    logic [DCNT_W-1:0] dcnt_inc;
    logic [7:0]        v_byte [STORE_SLOTS];

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);
    assign b       = i_q_head.data;

    assign err_inc = r_err_run + 4'd1;
    assign lim     = (r_err_limit == 4'd0) ? 4'd1 : r_err_limit;
    assign sum_add = r_sum + b;
    assign dcnt_inc = r_dcnt + DCNT_W'(1);

    // store slots with the current byte bypassed in, for the checksum beat
    always_comb begin
        for (int k = 0; k < STORE_SLOTS; k++) begin
            v_byte[k] = (take && r_widx == STORE_MAP[k]) ? b : r_store[k];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_exp_len = r_exp_len;
        n_dcnt    = r_dcnt;
        n_err_run = r_err_run;
        n_status  = ST_BUSY;
        n_upd     = 1'b0;
        n_midx    = 1'b0;
        n_kind    = 8'd0;
        n_rpm     = 16'd0;
        n_pos     = 32'd0;
        take      = 1'b0;
        restart   = 1'b0;
        err       = 1'b0;

        unique case (r_phase)
            PH_HDR: begin
                if (i_q_head.is_hdr) begin
                    take      = 1'b1;
                    n_err_run = 4'd0;
                    n_hdr_cnt = ~r_hdr_cnt;
                    if (r_hdr_cnt) begin
                        n_phase = PH_ID;
                    end
                end else begin
                    err      = 1'b1;
                    n_status = ST_HDR_ERR;
                end
            end
            PH_ID: begin
                if (i_q_head.is_id) begin
                    take      = 1'b1;
                    n_err_run = 4'd0;
                    n_phase   = PH_PID;
                end else begin
                    err      = 1'b1;
                    n_status = ST_ID_ERR;
                end
            end
            PH_PID: begin
                take    = 1'b1;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                take      = 1'b1;
                n_exp_len = b;
                n_dcnt    = '0;
                n_phase   = PH_DATA;
            end
            PH_DATA: begin
                take   = 1'b1;
                n_dcnt = dcnt_inc;
                if (32'(dcnt_inc) >= 32'(DATA_LIMIT)) begin
                    n_status = ST_TOO_LONG;
                    restart  = 1'b1;
                end else if ({{(8 - DCNT_W){1'b0}}, dcnt_inc} >= r_exp_len) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                take    = 1'b1;
                restart = 1'b1;
                n_kind  = v_byte[SLOT_PID];
                if (sum_add == 8'd0) begin
                    n_status = ST_OK;
                    if (v_byte[SLOT_PID] == MAIN_DATA_PID) begin
                        n_rpm = {v_byte[SLOT_RPM1], v_byte[SLOT_RPM0]};
                        n_pos = {v_byte[SLOT_POS3], v_byte[SLOT_POS2],
                                 v_byte[SLOT_POS1], v_byte[SLOT_POS0]};
                        if (v_byte[SLOT_ID] == r_motor_a_id) begin
                            n_upd = 1'b1;
                        end else if (v_byte[SLOT_ID] == r_motor_b_id) begin
                            n_upd  = 1'b1;
                            n_midx = 1'b1;
                        end
                    end
                end else begin
                    n_status = ST_CSUM_ERR;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        err_limit_hit = err && (err_inc >= lim);
        if (err) begin
            restart   = 1'b1;
            n_err_run = err_limit_hit ? 4'd0 : err_inc;
            if (err_limit_hit) begin
                n_status = ST_ERR_LIMIT;
            end
        end

        n_sum  = take ? sum_add : r_sum;
        n_widx = r_widx;
        if (take && 32'(r_widx) < PACKET_DEPTH) begin
            n_widx = r_widx + t_widx'(1);
        end
        for (int k = 0; k < STORE_SLOTS; k++) begin
            n_store[k] = err_limit_hit ? 8'd0 : v_byte[k];
        end

        if (restart) begin
            n_phase   = PH_HDR;
            n_hdr_cnt = 1'b0;
            n_sum     = 8'd0;
            n_exp_len = 8'd0;
            n_dcnt    = '0;
            n_widx    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_a_id <= RST_MOTOR_A_ID;
            r_motor_b_id <= RST_MOTOR_B_ID;
            r_err_limit  <= RST_ERR_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MOTOR_A_ID: r_motor_a_id <= i_cfg_data;
                CFG_MOTOR_B_ID: r_motor_b_id <= i_cfg_data;
                CFG_ERR_LIMIT:  r_err_limit  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_hdr_cnt <= 1'b0;
            r_sum     <= 8'd0;
            r_exp_len <= 8'd0;
            r_dcnt    <= '0;
            r_err_run <= 4'd0;
            r_widx    <= '0;
            for (int k = 0; k < STORE_SLOTS; k++) begin
                r_store[k] <= 8'd0;
            end
        end else if (o_q_pop) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_sum     <= n_sum;
            r_exp_len <= n_exp_len;
            r_dcnt    <= n_dcnt;
            r_err_run <= n_err_run;
            r_widx    <= n_widx;
            for (int k = 0; k < STORE_SLOTS; k++) begin
                r_store[k] <= n_store[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
            r_upd    <= n_upd;
            r_midx   <= n_midx;
            r_kind   <= n_kind;
            r_rpm    <= n_rpm;
            r_pos    <= n_pos;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_motor_update = r_upd;
    assign o_motor_index  = r_midx;
    assign o_packet_kind  = r_kind;
    assign o_speed_rpm    = $signed(r_rpm);
    assign o_position     = $signed(r_pos);

endmodule

// ===== design/motor_status_packet_receiver.sv =====
// Motor status packet receiver: top level joining the byte front end, the
// queue it holds and the deframing back end. Depends on msp_pkg, msp_front, msp_back.
//
// Input channel: one received byte per beat on i_rx_byte, i_in_valid / o_in_stall.
// Output channel: exactly one result beat per input byte on o_out_valid /
// i_out_stall, carrying status (0 while a packet is still in progress),
// motor update flag and index, packet id, rpm and position.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 motor A id, 1 motor B id, 2 error limit); other indexes are ignored.
// Write only while no byte is in flight.
// An accepted byte is written into the queue, and its result is registered in the
// result register when the back end takes it. Throughput: one byte per cycle while i_out_stall is low.
// A two-entry queue separates the front from the back end, and lets the next
// bytes be taken while a result is still waiting in the result register.
// When the receiver stalls, the result holds, the queue fills and
// o_in_stall rises once both entries are in use.
// Reset (i_rst_n low, synchronous) empties the queue, drops any waiting result,
// returns to header search, clears the packet store and restores defaults.
module motor_status_packet_receiver
    import msp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_motor_update,
    output logic               o_motor_index,
    output logic [7:0]         o_packet_kind,
    output logic signed [15:0] o_speed_rpm,
    output logic signed [31:0] o_position
);

    logic q_valid;
    logic q_pop;
    t_cls q_head;

    msp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .o_q_valid  (q_valid),
        .o_q_head   (q_head),
        .i_q_pop    (q_pop)
    );

    msp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_motor_update (o_motor_update),
        .o_motor_index  (o_motor_index),
        .o_packet_kind  (o_packet_kind),
        .o_speed_rpm    (o_speed_rpm),
        .o_position     (o_position)
    );

endmodule

// ===== test/motor_status_packet_receiver_tb.sv =====
// Testbench for motor_status_packet_receiver: directed frames, then random packet traffic
// and line noise, each result beat checked against a scoreboard that deframes the same bytes.
// Depends on msp_pkg and the motor_status_packet_receiver RTL; needs nothing else.
module motor_status_packet_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msp_pkg::*;

    // byte offsets into the stored frame
    localparam int OFS_ID  = 2;
    localparam int OFS_PID = 3;
    localparam int OFS_RPM = 5;
    localparam int OFS_POS = 15;

    // bytes sent over the whole run, directed part included
    localparam int ITEM_TARGET = 1300;

    typedef logic [7:0] t_byte_q[$];

    typedef struct packed {
        t_status            status;
        logic               motor_update;
        logic               motor_index;
        logic [7:0]         packet_kind;
        logic signed [15:0] speed_rpm;
        logic signed [31:0] position;
    } t_frame_result;

    class status_scoreboard;
        typedef enum {SEEK_HDR, SEEK_ID, SEEK_PID, SEEK_LEN, IN_DATA, SEEK_CSUM} t_rx_phase;

        logic [7:0]    id_a, id_b;
        logic [3:0]    err_limit;
        t_rx_phase     phase;
        int unsigned   hdr_seen, data_seen, err_run, wr_idx;
        logic [7:0]    sum, frame_len;
        logic [7:0]    store [PACKET_DEPTH];
        t_frame_result expected_results[$];
        int            failures;

        function new();
            id_a      = RST_MOTOR_A_ID;
            id_b      = RST_MOTOR_B_ID;
            err_limit = RST_ERR_LIMIT;
            err_run   = 0;
            failures  = 0;
            foreach (store[i]) store[i] = '0;
            restart();
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_MOTOR_A_ID: id_a = val;
                CFG_MOTOR_B_ID: id_b = val;
                CFG_ERR_LIMIT:  err_limit = val[3:0];
                default: ;
            endcase
        endfunction

        function void restart();
            phase     = SEEK_HDR;
            hdr_seen  = 0;
            sum       = '0;
            frame_len = '0;
            data_seen = 0;
            wr_idx    = 0;
        endfunction

        function void take(logic [7:0] b);
            sum += b;
            if (wr_idx < PACKET_DEPTH) begin
                store[wr_idx] = b;
                wr_idx++;
            end
        endfunction

        function t_status count_error(t_status code);
            int unsigned lim;
            lim = (err_limit == 0) ? 1 : err_limit;
            restart();
            err_run = (err_run + 1) & 15;
            if (err_run >= lim) begin
                err_run = 0;
                foreach (store[i]) store[i] = '0;
                return ST_ERR_LIMIT;
            end
            return code;
        endfunction

        function t_frame_result deframe_byte(logic [7:0] b);
            t_frame_result r;
            logic [7:0]    chan;
            r = '0;
            r.status = ST_BUSY;
            case (phase)
                SEEK_HDR: begin
                    if (b == HDR_A || b == HDR_B) begin
                        take(b);
                        err_run = 0;
                        hdr_seen++;
                        if (hdr_seen >= 2) begin
                            hdr_seen = 0;
                            phase = SEEK_ID;
                        end
                    end else begin
                        r.status = count_error(ST_HDR_ERR);
                    end
                end
                SEEK_ID: begin
                    if (b == ID_ONE || b == ID_TWO) begin
                        take(b);
                        err_run = 0;
                        phase = SEEK_PID;
                    end else begin
                        r.status = count_error(ST_ID_ERR);
                    end
                end
                SEEK_PID: begin
                    take(b);
                    phase = SEEK_LEN;
                end
                SEEK_LEN: begin
                    frame_len = b;
                    data_seen = 0;
                    take(b);
                    phase = IN_DATA;
                end
                IN_DATA: begin
                    take(b);
                    data_seen++;
                    if (data_seen >= DATA_LIMIT) begin
                        r.status = ST_TOO_LONG;
                        restart();
                    end else if (data_seen >= frame_len) begin
                        phase = SEEK_CSUM;
                    end
                end
                SEEK_CSUM: begin
                    take(b);
                    r.packet_kind = store[OFS_PID];
                    if (sum == 0) begin
                        r.status = ST_OK;
                        if (store[OFS_PID] == MAIN_DATA_PID) begin
                            chan = store[OFS_ID];
                            r.speed_rpm = {store[OFS_RPM + 1], store[OFS_RPM]};
                            r.position  = {store[OFS_POS + 3], store[OFS_POS + 2],
                                           store[OFS_POS + 1], store[OFS_POS]};
                            // channel A wins when both ids match
                            if (chan == id_a) begin
                                r.motor_update = 1'b1;
                                r.motor_index  = 1'b0;
                            end else if (chan == id_b) begin
                                r.motor_update = 1'b1;
                                r.motor_index  = 1'b1;
                            end
                        end
                    end else begin
                        r.status = ST_CSUM_ERR;
                    end
                    restart();
                end
                default: restart();
            endcase
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            expected_results.push_back(deframe_byte(b));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with no byte outstanding");
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.motor_update != want.motor_update) begin
                $error("motor_update: expected %0d, got %0d", want.motor_update,
                       got.motor_update);
                failures++;
            end
            if (got.motor_index != want.motor_index) begin
                $error("motor_index: expected %0d, got %0d", want.motor_index,
                       got.motor_index);
                failures++;
            end
            if (got.packet_kind != want.packet_kind) begin
                $error("packet_kind: expected %0d, got %0d", want.packet_kind,
                       got.packet_kind);
                failures++;
            end
            if (got.speed_rpm != want.speed_rpm) begin
                $error("speed_rpm: expected %0d, got %0d", want.speed_rpm, got.speed_rpm);
                failures++;
            end
            if (got.position != want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                failures++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         status;
    logic               motor_update;
    logic               motor_index;
    logic [7:0]         packet_kind;
    logic signed [15:0] speed_rpm;
    logic signed [31:0] position;

    int in_idle    = 8;
    int out_idle   = 8;
    int bytes_sent = 0;
    status_scoreboard sb;

    motor_status_packet_receiver dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_motor_update (motor_update),
        .o_motor_index  (motor_index),
        .o_packet_kind  (packet_kind),
        .o_speed_rpm    (speed_rpm),
        .o_position     (position)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < out_idle);
    end

    // result checked before the byte of the same edge is noted; latency keeps them apart
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(t_frame_result'({status, motor_update, motor_index,
                                                 packet_kind, speed_rpm, position}));
            if (in_valid && !in_stall)
                sb.note_byte(rx_byte);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < in_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    function automatic logic [7:0] header_byte();
        return $urandom_range(1) ? HDR_A : HDR_B;
    endfunction

    function automatic logic [7:0] non_header();
        logic [7:0] b;
        do b = 8'($urandom); while (b == HDR_A || b == HDR_B);
        return b;
    endfunction

    function automatic t_byte_q main_body(logic [15:0] rpm, logic [31:0] pos, int n);
        t_byte_q q;
        for (int i = 0; i < n; i++) q.push_back(8'($urandom));
        if (n > 1) begin
            q[0] = rpm[7:0];
            q[1] = rpm[15:8];
        end
        if (n > 13) begin
            q[10] = pos[7:0];
            q[11] = pos[15:8];
            q[12] = pos[23:16];
            q[13] = pos[31:24];
        end
        return q;
    endfunction

    // full frame; a length at or over the limit gets just enough data to abort
    task automatic send_packet(input logic [7:0] chan, input logic [7:0] pid,
                               input logic [7:0] frame_len, input t_byte_q body,
                               input bit good_sum);
        t_byte_q    pkt;
        logic [7:0] total;
        int         n;
        pkt.push_back(header_byte());
        pkt.push_back(header_byte());
        pkt.push_back(chan);
        pkt.push_back(pid);
        pkt.push_back(frame_len);
        n = (frame_len >= DATA_LIMIT) ? DATA_LIMIT : ((frame_len == 0) ? 1 : frame_len);
        for (int i = 0; i < n; i++) pkt.push_back((i < body.size()) ? body[i] : 8'($urandom));
        if (frame_len < DATA_LIMIT) begin
            total = '0;
            foreach (pkt[i]) total += pkt[i];
            total = -total;
            if (!good_sum) total += 8'($urandom_range(1, 255));
            pkt.push_back(total);
        end
        foreach (pkt[i]) send_byte(pkt[i]);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_motor_id();
        case ($urandom_range(5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(1, 2));
        endcase
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(3))
            0:       return 8'd1;
            1:       return 8'd15;
            default: return 8'($urandom_range(1, 15));
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        int         stop_at;
        int         pick;
        logic [7:0] frame_len;
        logic [7:0] pid;
        logic [7:0] bad_id;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                pid = ($urandom_range(99) < 65) ? MAIN_DATA_PID : 8'($urandom);
                case ($urandom_range(9))
                    0:       frame_len = 8'($urandom_range(0, 13));
                    1:       frame_len = 8'($urandom_range(DATA_LIMIT, 255));
                    default: frame_len = 8'($urandom_range(14, DATA_LIMIT - 1));
                endcase
                send_packet($urandom_range(1) ? ID_ONE : ID_TWO, pid, frame_len,
                            main_body(16'($urandom), $urandom,
                                      (frame_len > DATA_LIMIT) ? DATA_LIMIT : frame_len),
                            $urandom_range(99) < 85);
            end else if (pick < 83) begin
                repeat ($urandom_range(1, 16)) send_byte(non_header());
            end else if (pick < 90) begin
                do bad_id = 8'($urandom); while (bad_id == ID_ONE || bad_id == ID_TWO);
                send_byte(header_byte());
                send_byte(header_byte());
                send_byte(bad_id);
            end else if (pick < 95) begin
                // abandoned frame: the next frame's bytes land in its data
                send_byte(header_byte());
                send_byte(header_byte());
                send_byte($urandom_range(1) ? ID_ONE : ID_TWO);
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_packet(ID_ONE, MAIN_DATA_PID, 8'd14, main_body(16'h8000, 32'h7FFF_FFFF, 14), 1'b1);
        send_packet(ID_TWO, MAIN_DATA_PID, 8'd16, main_body(16'h7FFF, 32'h8000_0000, 16), 1'b1);
        // zero length still carries one data byte
        send_packet(ID_ONE, 8'h00, 8'd0, main_body(16'h0, 32'h0, 1), 1'b1);
        // short main-data frame: position comes from older frames
        send_packet(ID_TWO, MAIN_DATA_PID, 8'd2, main_body(16'h1234, 32'h0, 2), 1'b1);
        send_packet(ID_ONE, MAIN_DATA_PID, 8'd14, main_body(16'h5A5A, 32'h0, 14), 1'b0);
        send_packet(ID_ONE, 8'hFF, 8'd255, main_body(16'h0, 32'h0, DATA_LIMIT), 1'b1);
        send_byte(HDR_B);
        send_byte(HDR_A);
        send_byte(8'd3);

        settle();
        write_reg(CFG_ERR_LIMIT, 8'd1);
        send_byte(8'h55);
        send_packet(ID_TWO, MAIN_DATA_PID, 8'd1, main_body(16'h0, 32'h0, 1), 1'b1);

        settle();
        write_reg(CFG_MOTOR_A_ID, 8'd0);
        write_reg(CFG_MOTOR_B_ID, 8'd255);
        write_reg(CFG_ERR_LIMIT, 8'd15);
        send_packet(ID_ONE, MAIN_DATA_PID, 8'd14, main_body(16'h0001, 32'h1, 14), 1'b1);

        settle();
        write_reg(CFG_MOTOR_A_ID, 8'd2);
        write_reg(CFG_MOTOR_B_ID, 8'd2);
        send_packet(ID_TWO, MAIN_DATA_PID, 8'd15, main_body(16'hFFFF, 32'hFFFF_FFFF, 15), 1'b1);
        repeat (16) send_byte(non_header());

        for (int p = 0; bytes_sent < ITEM_TARGET; p++) begin
            settle();
            // one phase runs with both sides flat out
            in_idle  = (p == 2) ? 0 : 8;
            out_idle = (p == 2) ? 0 : 8;
            write_reg(CFG_MOTOR_A_ID, pick_motor_id());
            write_reg(CFG_MOTOR_B_ID, pick_motor_id());
            write_reg(CFG_ERR_LIMIT, pick_limit());
            random_traffic((ITEM_TARGET - bytes_sent < 220) ? ITEM_TARGET - bytes_sent : 220);
        end

        settle();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("motor_status_packet_receiver_tb passed");
        else
            $display("motor_status_packet_receiver_tb failed");
        $finish;
    end

    initial begin
        #400_000;
        $display("motor_status_packet_receiver_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/msp_pkg.sv
design/msp_front.sv
design/msp_back.sv
design/motor_status_packet_receiver.sv
test/motor_status_packet_receiver_tb.sv
